// ===== hw/rtl/dwbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dwbs_pkg
// Shared constants for the deviation weighted block smoother.
// ----------------------------------------------------------------------------
package dwbs_pkg;

    // defaults for the top level parameters
    localparam int BLOCK_LEN_DEF   = 5;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed port widths
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 26;

    // fraction bits of the result
    localparam int FRAC_W = 8;

    // quotient bits resolved per divider cycle
    localparam int DIV_RADIX_BITS = 4;

    // result saturation limits (magnitudes)
    localparam int OUT_MAX     = (2 ** (OUT_W - 1)) - 1;
    localparam int OUT_MIN_MAG = 2 ** (OUT_W - 1);

endpackage

// ===== hw/rtl/dwbs_store.sv =====
// ----------------------------------------------------------------------------
// dwbs_store
// Sample memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dwbs_store #(
    parameter int DEPTH  = dwbs_pkg::BLOCK_LEN_DEF,
    parameter int DATA_W = dwbs_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data registered on rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/dwbs_stats.sv =====
// ----------------------------------------------------------------------------
// dwbs_stats
// Block-end pass accumulator: compares each stored sample, scaled by N,
// against the block sum and gathers P-Q and the sum of positive deviations.
// ----------------------------------------------------------------------------
module dwbs_stats #(
    parameter int BLOCK_LEN   = dwbs_pkg::BLOCK_LEN_DEF,
    parameter int SAMPLE_BITS = dwbs_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(BLOCK_LEN) + 1,
    parameter int DEV_W       = SAMPLE_BITS + 2 * $clog2(BLOCK_LEN) + 1,
    parameter int PQ_W        = $clog2(BLOCK_LEN + 1) + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clr,
    input  logic                    en,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SUM_W-1:0] sum,
    output logic signed [PQ_W-1:0]  pq,
    output logic [DEV_W-1:0]        dev
);

    localparam logic signed [SUM_W-1:0] N_S = SUM_W'(BLOCK_LEN);

    logic signed [SUM_W-1:0] scaled;
    logic signed [SUM_W:0]   diff;
    logic                    gt;
    logic                    lt;
    logic signed [PQ_W-1:0]  pq_reg;
    logic [DEV_W-1:0]        dev_reg;

    // x*N against S
    always_comb
    begin
        scaled = SUM_W'(x) * N_S;
        diff   = (SUM_W + 1)'(scaled) - (SUM_W + 1)'(sum);
        gt     = (diff > 0);
        lt     = (diff < 0);
    end

    // accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pq_reg  <= '0;
            dev_reg <= '0;
        end
        else if (clr)
        begin
            pq_reg  <= '0;
            dev_reg <= '0;
        end
        else if (en)
        begin
            if (gt)
            begin
                pq_reg  <= pq_reg + PQ_W'(1);
                dev_reg <= dev_reg + DEV_W'(diff);
            end
            else if (lt)
            begin
                pq_reg <= pq_reg - PQ_W'(1);
            end
        end
    end

    assign pq  = pq_reg;
    assign dev = dev_reg;

endmodule

// ===== hw/rtl/dwbs_div.sv =====
// ----------------------------------------------------------------------------
// dwbs_div
// Restoring divider by a constant, several quotient bits per cycle.
// Quotient holds after done until the next start.
// ----------------------------------------------------------------------------
module dwbs_div #(
    parameter int DV_W    = 40,
    parameter int DIVISOR = dwbs_pkg::BLOCK_LEN_DEF ** 3,
    parameter int V_W     = $clog2(DIVISOR + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [DV_W-1:0] dividend,
    output logic            done,
    output logic [DV_W-1:0] quotient
);

    localparam int R    = dwbs_pkg::DIV_RADIX_BITS;
    localparam int ITER = DV_W / R;
    localparam int IC_W = $clog2(ITER + 1);
    localparam logic [V_W:0] DIV_EXT = (V_W + 1)'(DIVISOR);

    logic [DV_W-1:0] quo_reg;
    logic [V_W-1:0]  rem_reg;
    logic [IC_W-1:0] iter_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DV_W-1:0] quo_next;
    logic [V_W-1:0]  rem_next;

    // R shift-compare-subtract steps on the narrow remainder
    always_comb
    begin
        logic [V_W:0] trial;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int k = 0; k < R; k++)
        begin
            trial    = {rem_next, quo_next[DV_W-1]};
            quo_next = {quo_next[DV_W-2:0], 1'b0};
            if (trial >= DIV_EXT)
            begin
                trial       = trial - DIV_EXT;
                quo_next[0] = 1'b1;
            end
            rem_next = trial[V_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            iter_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                iter_reg <= IC_W'(ITER);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                iter_reg <= iter_reg - IC_W'(1);
                if (iter_reg == IC_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/deviation_weighted_block_smoother_top.sv =====
// ----------------------------------------------------------------------------
// deviation_weighted_block_smoother_top
// Block smoother: mean of N samples corrected by (P-Q)*TD/N^2, Q8 result.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a block fills (sample_ready high) and
// stored in a small synchronous memory; the N-th sample of a block yields one
// result, the others none. After the N-th sample the block reads the memory
// back once, forms the numerator in a multiply and an add step and divides it
// by N^3 in a constant divider that resolves 4 quotient bits a cycle (DV_W,
// the dividend width, is rounded up to a multiple of 4), then loads the
// output register. The result waits in its output register, so the next
// block fills while it is held; sample_ready stays low from the N-th sample
// until the result is loaded: during the block-end pass, the numerator and
// the division, and while a finished result cannot yet be loaded.
// ----------------------------------------------------------------------------
module deviation_weighted_block_smoother_top #(
    parameter int BLOCK_LEN   = dwbs_pkg::BLOCK_LEN_DEF,
    parameter int SAMPLE_BITS = dwbs_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_ready,
    input  logic signed [dwbs_pkg::SAMPLE_W-1:0] sample,
    output logic                                 smoothed_valid,
    input  logic                                 smoothed_ready,
    output logic signed [dwbs_pkg::OUT_W-1:0]    smoothed
);

    localparam int OUT_W  = dwbs_pkg::OUT_W;
    localparam int FRAC_W = dwbs_pkg::FRAC_W;
    localparam int R      = dwbs_pkg::DIV_RADIX_BITS;
    localparam int AW     = $clog2(BLOCK_LEN);
    localparam int RAW_W  = (SAMPLE_BITS > dwbs_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                : dwbs_pkg::SAMPLE_W;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(BLOCK_LEN) + 1;
    localparam int DEV_W  = SAMPLE_BITS + 2 * $clog2(BLOCK_LEN) + 1;
    localparam int PQ_W   = $clog2(BLOCK_LEN + 1) + 1;
    localparam int NUM_W  = PQ_W + DEV_W + 2;
    localparam int DV_W   = ((NUM_W + FRAC_W + R - 1) / R) * R;
    localparam int CMP_W  = (DV_W > OUT_W) ? DV_W : OUT_W + 1;
    localparam int N3     = BLOCK_LEN * BLOCK_LEN * BLOCK_LEN;
    localparam logic signed [NUM_W-1:0] N2_S = NUM_W'(BLOCK_LEN * BLOCK_LEN);

    typedef enum logic [2:0] {
        ST_FILL,
        ST_PASS,
        ST_DRAIN,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [AW-1:0]            cnt_reg;
    logic [AW-1:0]            idx_reg;
    logic                     rd_vld_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [NUM_W-1:0]  prod_reg;
    logic signed [NUM_W-1:0]  sn2_reg;
    logic                     neg_reg;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  smoothed_reg;

    logic [RAW_W-1:0]              raw;
    logic signed [SAMPLE_BITS-1:0] x_in;
    logic                          in_beat;
    logic                          out_beat;
    logic                          rd_en;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic signed [PQ_W-1:0]        pq;
    logic [DEV_W-1:0]              dev;
    logic signed [NUM_W-1:0]       num;
    logic [NUM_W-1:0]              mag;
    logic [DV_W-1:0]               dividend;
    logic                          div_start;
    logic                          div_done;
    logic [DV_W-1:0]               quotient;
    logic [CMP_W-1:0]              q_ext;
    logic signed [OUT_W-1:0]       sat_val;
    logic                          out_load;

    // sample: low SAMPLE_BITS bits, sign-extended
    always_comb
    begin
        raw  = RAW_W'($unsigned(sample));
        x_in = $signed(raw[SAMPLE_BITS-1:0]);
    end

    // handshakes and datapath control
    always_comb
    begin
        sample_ready = (state_reg == ST_FILL);
        in_beat      = sample_valid && sample_ready;
        out_beat     = out_valid_reg && smoothed_ready;
        rd_en        = (state_reg == ST_PASS);
        div_start    = (state_reg == ST_ADD);
        out_load     = (state_reg == ST_OUT) && (!out_valid_reg || smoothed_ready);
    end

    // numerator magnitude, scaled by 2^FRAC_W
    always_comb
    begin
        num      = prod_reg + sn2_reg;
        mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dividend = DV_W'({mag, {FRAC_W{1'b0}}});
    end

    // sign, saturation
    always_comb
    begin
        q_ext = CMP_W'(quotient);
        if (!neg_reg)
        begin
            if (q_ext > CMP_W'(dwbs_pkg::OUT_MAX))
            begin
                sat_val = OUT_W'(dwbs_pkg::OUT_MAX);
            end
            else
            begin
                sat_val = $signed(q_ext[OUT_W-1:0]);
            end
        end
        else
        begin
            if (q_ext > CMP_W'(dwbs_pkg::OUT_MIN_MAG))
            begin
                sat_val = $signed({1'b1, {(OUT_W - 1){1'b0}}});
            end
            else
            begin
                sat_val = -$signed(q_ext[OUT_W-1:0]);
            end
        end
    end

    dwbs_store #(
        .DEPTH  (BLOCK_LEN),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (in_beat),
        .wr_addr (cnt_reg),
        .wr_data (x_in),
        .rd_en   (rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    dwbs_stats #(
        .BLOCK_LEN   (BLOCK_LEN),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W),
        .DEV_W       (DEV_W),
        .PQ_W        (PQ_W)
    ) u_stats (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (state_reg == ST_FILL),
        .en    (rd_vld_reg),
        .x     ($signed(rd_data)),
        .sum   (sum_reg),
        .pq    (pq),
        .dev   (dev)
    );

    dwbs_div #(
        .DV_W    (DV_W),
        .DIVISOR (N3),
        .V_W     ($clog2(N3 + 1))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    // sequencer, running sum and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            sum_reg       <= '0;
            prod_reg      <= '0;
            sn2_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            smoothed_reg  <= '0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            // a beat that is replaced by a new result in the same cycle stays valid
            if (out_beat && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_FILL:
                begin
                    if (in_beat)
                    begin
                        sum_reg <= sum_reg + SUM_W'(x_in);
                        if (cnt_reg == AW'(BLOCK_LEN - 1))
                        begin
                            cnt_reg   <= '0;
                            idx_reg   <= '0;
                            state_reg <= ST_PASS;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + AW'(1);
                        end
                    end
                end
                ST_PASS:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (idx_reg == AW'(BLOCK_LEN - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg  <= NUM_W'(pq) * $signed(NUM_W'(dev));
                    sn2_reg   <= NUM_W'(sum_reg) * N2_S;
                    sum_reg   <= '0;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    neg_reg   <= num[NUM_W-1];
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        smoothed_reg  <= sat_val;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_FILL;
                    end
                end
                default:
                begin
                    state_reg <= ST_FILL;
                end
            endcase
        end
    end

    assign smoothed_valid = out_valid_reg;
    assign smoothed       = smoothed_reg;

endmodule

// ===== hw/rtl/dwbs_checker.sv =====
// ----------------------------------------------------------------------------
// dwbs_checker
// Port-level checks of the smoother: block accounting and output hold.
// ----------------------------------------------------------------------------
module dwbs_checker #(
    parameter int BLOCK_LEN = dwbs_pkg::BLOCK_LEN_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 sample_valid,
    input logic                                 sample_ready,
    input logic                                 smoothed_valid,
    input logic                                 smoothed_ready,
    input logic signed [dwbs_pkg::OUT_W-1:0]    smoothed
);

    localparam int AW = $clog2(BLOCK_LEN);

    logic [AW-1:0] blk_cnt_reg;
    logic [2:0]    owed_reg;
    logic          in_beat;
    logic          out_beat;
    logic          blk_end;

    always_comb
    begin
        in_beat  = sample_valid && sample_ready;
        out_beat = smoothed_valid && smoothed_ready;
        blk_end  = in_beat && (blk_cnt_reg == AW'(BLOCK_LEN - 1));
    end

    // samples seen in the current block, results owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_cnt_reg <= '0;
            owed_reg    <= '0;
        end
        else
        begin
            if (blk_end)
            begin
                blk_cnt_reg <= '0;
            end
            else if (in_beat)
            begin
                blk_cnt_reg <= blk_cnt_reg + AW'(1);
            end
            owed_reg <= owed_reg + 3'(blk_end) - 3'(out_beat);
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        smoothed_valid && !smoothed_ready |=> smoothed_valid && $stable(smoothed))
        else $error("result changed while stalled");

    // no result without a completed block
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        smoothed_valid |-> owed_reg != 3'd0)
        else $error("result without a completed block");

    // at most one held and one finishing block
    a_owed_bound: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg <= 3'd2)
        else $error("completed blocks piled up");

    // the last sample of a block starts the block-end pass
    a_pass_stall: assert property (@(posedge clk) disable iff (!rst_n)
        blk_end |=> !sample_ready)
        else $error("sample taken during block-end pass");

endmodule

bind deviation_weighted_block_smoother_top dwbs_checker #(
    .BLOCK_LEN (BLOCK_LEN)
) u_dwbs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .smoothed_valid (smoothed_valid),
    .smoothed_ready (smoothed_ready),
    .smoothed       (smoothed)
);
